// ----- src/trs_model_matrix_builder_assert.svh -----
// Assertion macros for the model matrix builder.
// Taken in by the top level; no other dependencies.
`ifndef TRS_MODEL_MATRIX_BUILDER_ASSERT_SVH
`define TRS_MODEL_MATRIX_BUILDER_ASSERT_SVH

// same-cycle implication
`define TRSMB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trsmb: same-cycle check failed");

// next-cycle implication
`define TRSMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trsmb: next-cycle check failed");

`endif

// ----- src/trsmb_pkg.sv -----
// Package for the model matrix builder: transfer payload types, fixed-point
// constants and the Horner divisor and reciprocal tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package trsmb_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int ANGLE_BITS_DEF = 16;

   localparam int HORNER_STEPS = 7;
   localparam int CH_SIN       = 0;
   localparam int CH_COS       = 1;
   localparam int AX           = 0;
   localparam int AY           = 1;
   localparam int AZ           = 2;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   localparam logic [3:0]  LAST_INDEX = 4'd15;
   localparam logic [1:0]  LAST_ROW   = 2'd3;
   localparam logic [1:0]  LAST_COL   = 2'd3;

   localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

   typedef struct packed {
      logic [15:0]        angle_x;
      logic [15:0]        angle_y;
      logic [15:0]        angle_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
   } trsmb_req_type;

   typedef struct packed {
      logic signed [31:0] element_value;
      logic [3:0]         element_index;
      logic               last_element;
   } trsmb_rsp_type;

   // n*(n-1) for the Horner step; sine runs steps 1..6, cosine 0..6
   function automatic logic [7:0] horner_div(input logic is_cos, input logic [2:0] step);
      logic [7:0] d;
      d = 8'd2;
      if (is_cos) begin
         case (step)
            3'd0:    d = 8'd182;
            3'd1:    d = 8'd132;
            3'd2:    d = 8'd90;
            3'd3:    d = 8'd56;
            3'd4:    d = 8'd30;
            3'd5:    d = 8'd12;
            default: d = 8'd2;
         endcase
      end else begin
         case (step)
            3'd1:    d = 8'd156;
            3'd2:    d = 8'd110;
            3'd3:    d = 8'd72;
            3'd4:    d = 8'd42;
            3'd5:    d = 8'd20;
            default: d = 8'd6;
         endcase
      end
      return d;
   endfunction

   // floor(2^32 / horner_div)
   function automatic logic [31:0] horner_recip(input logic is_cos, input logic [2:0] step);
      logic [31:0] m;
      m = 32'd715827882;
      if (is_cos) begin
         case (step)
            3'd0:    m = 32'd23598721;
            3'd1:    m = 32'd32537631;
            3'd2:    m = 32'd47721858;
            3'd3:    m = 32'd76695844;
            3'd4:    m = 32'd143165576;
            3'd5:    m = 32'd357913941;
            default: m = 32'd2147483648;
         endcase
      end else begin
         case (step)
            3'd1:    m = 32'd27531841;
            3'd2:    m = 32'd39045157;
            3'd3:    m = 32'd59652323;
            3'd4:    m = 32'd102261126;
            3'd5:    m = 32'd214748364;
            default: m = 32'd715827882;
         endcase
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- src/trs_model_matrix_builder.sv -----
// Model matrix builder top level: 32-stage pipeline plus element serializer.
// Depends on trsmb_pkg and trs_model_matrix_builder_assert.svh.
//
// Each accepted transfer (three binary angles, three Q16.16 scales, three
// Q16.16 offsets) yields the 16 elements of RX*RY*RZ*S*T, row-major, one
// element per cycle while rsp_stall is low, the sixteenth flagged by
// last_element. Sine and cosine come from a pipelined Horner series (seven
// multiply, reciprocal, correct steps of three stages each), followed by
// three matrix-product stages of multiply then round. Each finished matrix
// is registered into the serializer, whose single result port delivers one
// element a cycle while rsp_stall is low.
// Inputs are taken every cycle while the pipeline is free and freeze as a
// whole once a finished matrix waits for the serializer.
`timescale 1ns / 1ps
`default_nettype none
`include "trs_model_matrix_builder_assert.svh"

module trs_model_matrix_builder #(
   parameter int FRAC_BITS  = trsmb_pkg::FRAC_BITS_DEF,
   parameter int ANGLE_BITS = trsmb_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire trsmb_pkg::trsmb_req_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output trsmb_pkg::trsmb_rsp_type      rsp_data
);
   import trsmb_pkg::*;

   localparam int TW       = FRAC_BITS + 2;
   localparam int EW       = FRAC_BITS + 3;
   localparam int PW       = 2 * TW;
   localparam int GW       = EW + 32;
   localparam int RW       = ANGLE_BITS - 2;
   localparam int HS       = HORNER_STEPS;
   localparam int ST_X     = 1;
   localparam int ST_X2    = 2;
   localparam int ST_H0    = 3;
   localparam int ST_S     = ST_H0 + 3 * HS;
   localparam int ST_TRIG  = ST_S + 1;
   localparam int ST_M1    = ST_TRIG + 1;
   localparam int ST_R1    = ST_M1 + 1;
   localparam int ST_M2    = ST_R1 + 1;
   localparam int ST_R2    = ST_M2 + 1;
   localparam int ST_M3    = ST_R2 + 1;
   localparam int ST_R3    = ST_M3 + 1;
   localparam int NSTAGE   = ST_R3 + 1;
   localparam int FR_SHIFT = 30 - FRAC_BITS;
   localparam logic [31:0] FR_HALF = 32'd1 << (29 - FRAC_BITS);
   localparam logic [31:0] ONE_FX  = 32'd1 << FRAC_BITS;

   typedef struct packed {
      logic [30:0] x;
      logic [31:0] xsq;
      logic [1:0]  quad;
   } lane_type;

   typedef struct packed {
      logic [2:0][31:0] scale;
      logic [2:0][31:0] offset;
   } geo_type;

   typedef struct packed {
      logic signed [TW-1:0] sn;
      logic signed [TW-1:0] cs;
   } trig_type;

   function automatic logic signed [63:0] fx_round(input logic signed [63:0] v);
      return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // handshake and control
   logic [NSTAGE-1:0] vld_ff;
   logic              en;
   logic              load;
   logic              rsp_xfer;
   logic              ser_done;
   logic              ser_vld_ff;
   logic [3:0]        idx_ff;

   // pipeline payload
   logic [15:0]           ang_ff   [3];
   geo_type               geo_ff   [NSTAGE];
   lane_type              lane_ff  [ST_X:ST_S][3];
   logic [30:0]           x_in     [3];
   logic [31:0]           xsq_in   [3];
   logic [ANGLE_BITS-1:0] ang_c    [3];
   logic [RW+32:0]        xm_c     [3];
   logic [61:0]           xx_c     [3];

   logic [30:0] tin_c   [HS][3][2];
   logic [62:0] hmul_c  [HS][3][2];
   logic [63:0] rmul_c  [HS][3][2];
   logic [38:0] qd_c    [HS][3][2];
   logic [31:0] rem_c   [HS][3][2];
   logic [30:0] dq_c    [HS][3][2];
   logic [31:0] hp_in   [HS][3][2];
   logic [31:0] hp_ff   [HS][3][2];
   logic [30:0] hq_in   [HS][3][2];
   logic [30:0] hq_ff   [HS][3][2];
   logic [31:0] hpq_ff  [HS][3][2];
   logic [30:0] ht_in   [HS][3][2];
   logic [30:0] ht_ff   [HS][3][2];

   logic [61:0]          sm_c   [3];
   logic [30:0]          s_c    [3];
   logic [30:0]          mag_in [3][2];
   logic [30:0]          mag_ff [3][2];
   logic signed [TW-1:0] fs_c   [3];
   logic signed [TW-1:0] fc_c   [3];
   trig_type             trg_in [3];
   trig_type             trg_ff [ST_TRIG:ST_R1][3];

   logic signed [PW-1:0] m1_in  [4];
   logic signed [PW-1:0] m1_ff  [4];
   logic signed [TW-1:0] p1_in  [4];
   logic signed [TW-1:0] p1_ff  [4];
   logic signed [PW-1:0] m2_in  [10];
   logic signed [PW-1:0] m2_ff  [10];
   logic signed [TW-1:0] car_ff [3];
   logic signed [EW-1:0] e_in   [3][3];
   logic signed [EW-1:0] e_ff   [3][3];
   logic signed [GW-1:0] m3_in  [3][3];
   logic signed [GW-1:0] m3_ff  [3][3];
   logic signed [31:0]   fin_in [3][3];
   logic signed [31:0]   fin_ff [3][3];

   logic signed [31:0] ser_ff     [3][3];
   logic [31:0]        ser_off_ff [3];
   logic signed [31:0] elem_c;

   // flow control: whole pipeline holds while a finished matrix waits
   assign rsp_xfer  = ser_vld_ff && !rsp_stall;
   assign ser_done  = rsp_xfer && (idx_ff == LAST_INDEX);
   assign load      = vld_ff[NSTAGE-1] && (!ser_vld_ff || ser_done);
   assign en        = !vld_ff[NSTAGE-1] || load;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         ser_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
         end
         if (rsp_xfer) begin
            idx_ff <= idx_ff + 4'd1;
         end
         if (load) begin
            ser_vld_ff <= 1'b1;
         end else if (ser_done) begin
            ser_vld_ff <= 1'b0;
         end
      end
   end

   // angle to radians, then x squared
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         ang_c[l]  = ANGLE_BITS'(ang_ff[l]);
         xm_c[l]   = (RW + 33)'(ang_c[l][RW-1:0]) * (RW + 33)'(TWO_PI_Q30);
         x_in[l]   = 31'(xm_c[l] >> ANGLE_BITS);
         xx_c[l]   = 62'(lane_ff[ST_X][l].x) * 62'(lane_ff[ST_X][l].x);
         xsq_in[l] = 32'(xx_c[l] >> 30);
      end
   end

   // Horner steps: product, reciprocal multiply, one-step correction
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         for (int c = 0; c < 2; c++) begin
            tin_c[0][l][c] = Q30_ONE;
            for (int k = 1; k < HS; k++) begin
               tin_c[k][l][c] = ht_ff[k-1][l][c];
            end
         end
      end
      for (int k = 0; k < HS; k++) begin
         for (int l = 0; l < 3; l++) begin
            for (int c = 0; c < 2; c++) begin
               hmul_c[k][l][c] = 63'(lane_ff[ST_H0 + 3 * k - 1][l].xsq)
                                 * 63'(tin_c[k][l][c]);
               hp_in[k][l][c]  = 32'(hmul_c[k][l][c] >> 30);
               rmul_c[k][l][c] = 64'(hp_ff[k][l][c])
                                 * 64'(horner_recip(c == CH_COS, 3'(k)));
               hq_in[k][l][c]  = 31'(rmul_c[k][l][c] >> 32);
               qd_c[k][l][c]   = 39'(hq_ff[k][l][c])
                                 * 39'(horner_div(c == CH_COS, 3'(k)));
               rem_c[k][l][c]  = hpq_ff[k][l][c] - qd_c[k][l][c][31:0];
               if (rem_c[k][l][c] >= 32'(horner_div(c == CH_COS, 3'(k)))) begin
                  dq_c[k][l][c] = hq_ff[k][l][c] + 31'd1;
               end else begin
                  dq_c[k][l][c] = hq_ff[k][l][c];
               end
               if (c == CH_SIN && k == 0) begin
                  ht_in[k][l][c] = Q30_ONE;
               end else if (dq_c[k][l][c] > Q30_ONE) begin
                  ht_in[k][l][c] = '0;
               end else begin
                  ht_in[k][l][c] = Q30_ONE - dq_c[k][l][c];
               end
            end
         end
      end
   end

   // sine = x * series, clamp, then quadrant and rounding to FRAC_BITS
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sm_c[l] = 62'(lane_ff[ST_S-1][l].x) * 62'(ht_ff[HS-1][l][CH_SIN]);
         s_c[l]  = 31'(sm_c[l] >> 30);
         mag_in[l][CH_SIN] = (s_c[l] > Q30_ONE) ? Q30_ONE : s_c[l];
         mag_in[l][CH_COS] = ht_ff[HS-1][l][CH_COS];
         fs_c[l] = TW'((32'(mag_ff[l][CH_SIN]) + FR_HALF) >> FR_SHIFT);
         fc_c[l] = TW'((32'(mag_ff[l][CH_COS]) + FR_HALF) >> FR_SHIFT);
         case (lane_ff[ST_S][l].quad)
            QUAD_0: begin
               trg_in[l].sn = fs_c[l];
               trg_in[l].cs = fc_c[l];
            end
            QUAD_1: begin
               trg_in[l].sn = fc_c[l];
               trg_in[l].cs = -fs_c[l];
            end
            QUAD_2: begin
               trg_in[l].sn = -fs_c[l];
               trg_in[l].cs = -fc_c[l];
            end
            default: begin
               trg_in[l].sn = -fc_c[l];
               trg_in[l].cs = fs_c[l];
            end
         endcase
      end
   end

   // RX*RY, then *RZ, then *S; translation only fills the bottom row
   always_comb begin
      m1_in[0] = trg_ff[ST_TRIG][AX].sn * trg_ff[ST_TRIG][AY].sn;
      m1_in[1] = -trg_ff[ST_TRIG][AX].sn * trg_ff[ST_TRIG][AY].cs;
      m1_in[2] = trg_ff[ST_TRIG][AX].cs * -trg_ff[ST_TRIG][AY].sn;
      m1_in[3] = trg_ff[ST_TRIG][AX].cs * trg_ff[ST_TRIG][AY].cs;
      for (int i = 0; i < 4; i++) begin
         p1_in[i] = TW'(fx_round(m1_ff[i]));
      end

      m2_in[0] = trg_ff[ST_R1][AY].cs * trg_ff[ST_R1][AZ].cs;
      m2_in[1] = trg_ff[ST_R1][AY].cs * -trg_ff[ST_R1][AZ].sn;
      m2_in[2] = p1_ff[0] * trg_ff[ST_R1][AZ].cs;
      m2_in[3] = trg_ff[ST_R1][AX].cs * trg_ff[ST_R1][AZ].sn;
      m2_in[4] = p1_ff[0] * -trg_ff[ST_R1][AZ].sn;
      m2_in[5] = trg_ff[ST_R1][AX].cs * trg_ff[ST_R1][AZ].cs;
      m2_in[6] = p1_ff[2] * trg_ff[ST_R1][AZ].cs;
      m2_in[7] = trg_ff[ST_R1][AX].sn * trg_ff[ST_R1][AZ].sn;
      m2_in[8] = p1_ff[2] * -trg_ff[ST_R1][AZ].sn;
      m2_in[9] = trg_ff[ST_R1][AX].sn * trg_ff[ST_R1][AZ].cs;

      e_in[0][0] = EW'(fx_round(m2_ff[0]));
      e_in[0][1] = EW'(fx_round(m2_ff[1]));
      e_in[0][2] = EW'(car_ff[0]);
      e_in[1][0] = EW'(fx_round(64'(m2_ff[2]) + 64'(m2_ff[3])));
      e_in[1][1] = EW'(fx_round(64'(m2_ff[4]) + 64'(m2_ff[5])));
      e_in[1][2] = EW'(car_ff[1]);
      e_in[2][0] = EW'(fx_round(64'(m2_ff[6]) + 64'(m2_ff[7])));
      e_in[2][1] = EW'(fx_round(64'(m2_ff[8]) + 64'(m2_ff[9])));
      e_in[2][2] = EW'(car_ff[2]);

      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            m3_in[i][j]  = e_ff[i][j] * $signed(geo_ff[ST_R2].scale[j]);
            fin_in[i][j] = sat32(fx_round(m3_ff[i][j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff[AX] <= req_data.angle_x;
         ang_ff[AY] <= req_data.angle_y;
         ang_ff[AZ] <= req_data.angle_z;
         geo_ff[0].scale  <= {req_data.scale_z, req_data.scale_y, req_data.scale_x};
         geo_ff[0].offset <= {req_data.offset_z, req_data.offset_y, req_data.offset_x};
         for (int s = 1; s < NSTAGE; s++) begin
            geo_ff[s] <= geo_ff[s-1];
         end
         for (int l = 0; l < 3; l++) begin
            lane_ff[ST_X][l].x    <= x_in[l];
            lane_ff[ST_X][l].xsq  <= '0;
            lane_ff[ST_X][l].quad <= ang_c[l][ANGLE_BITS-1 -: 2];
            lane_ff[ST_X2][l].x    <= lane_ff[ST_X][l].x;
            lane_ff[ST_X2][l].xsq  <= xsq_in[l];
            lane_ff[ST_X2][l].quad <= lane_ff[ST_X][l].quad;
            for (int s = ST_X2 + 1; s <= ST_S; s++) begin
               lane_ff[s][l] <= lane_ff[s-1][l];
            end
         end
         hp_ff  <= hp_in;
         hq_ff  <= hq_in;
         hpq_ff <= hp_ff;
         ht_ff  <= ht_in;
         mag_ff <= mag_in;
         trg_ff[ST_TRIG] <= trg_in;
         for (int s = ST_TRIG + 1; s <= ST_R1; s++) begin
            trg_ff[s] <= trg_ff[s-1];
         end
         m1_ff     <= m1_in;
         p1_ff     <= p1_in;
         m2_ff     <= m2_in;
         car_ff[0] <= trg_ff[ST_R1][AY].sn;
         car_ff[1] <= p1_ff[1];
         car_ff[2] <= p1_ff[3];
         e_ff      <= e_in;
         m3_ff     <= m3_in;
         fin_ff    <= fin_in;
      end
      if (load) begin
         ser_ff <= fin_ff;
         for (int j = 0; j < 3; j++) begin
            ser_off_ff[j] <= geo_ff[ST_R3].offset[j];
         end
      end
   end

   // element select: rotation-scale block, zero column, translation row
   always_comb begin
      elem_c = '0;
      if (idx_ff[3:2] == LAST_ROW) begin
         case (idx_ff[1:0])
            2'd0:    elem_c = ser_off_ff[0];
            2'd1:    elem_c = ser_off_ff[1];
            2'd2:    elem_c = ser_off_ff[2];
            default: elem_c = ONE_FX;
         endcase
      end else if (idx_ff[1:0] != LAST_COL) begin
         case (idx_ff[3:2])
            2'd0: begin
               case (idx_ff[1:0])
                  2'd0:    elem_c = ser_ff[0][0];
                  2'd1:    elem_c = ser_ff[0][1];
                  default: elem_c = ser_ff[0][2];
               endcase
            end
            2'd1: begin
               case (idx_ff[1:0])
                  2'd0:    elem_c = ser_ff[1][0];
                  2'd1:    elem_c = ser_ff[1][1];
                  default: elem_c = ser_ff[1][2];
               endcase
            end
            default: begin
               case (idx_ff[1:0])
                  2'd0:    elem_c = ser_ff[2][0];
                  2'd1:    elem_c = ser_ff[2][1];
                  default: elem_c = ser_ff[2][2];
               endcase
            end
         endcase
      end
   end

   assign rsp_valid              = ser_vld_ff;
   assign rsp_data.element_value = elem_c;
   assign rsp_data.element_index = idx_ff;
   assign rsp_data.last_element  = (idx_ff == LAST_INDEX);

   `TRSMB_ASSERT_SAME(a_idle_index, clock, reset, !ser_vld_ff, idx_ff == '0)
   `TRSMB_ASSERT_NEXT(a_drain, clock, reset, ser_done && !vld_ff[NSTAGE-1], !rsp_valid)
   `TRSMB_ASSERT_NEXT(a_freeze, clock, reset, req_stall, vld_ff == $past(vld_ff))

endmodule

`default_nettype wire
